>>> rtl/falling_sand_grid_engine_top_macros.svh
// Assertion macros shared by the grid engine modules.
`ifndef FALLING_SAND_GRID_ENGINE_TOP_MACROS_SVH
`define FALLING_SAND_GRID_ENGINE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSGE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fsge_pkg.sv
package fsge_pkg;

  // Default grid edge, border ring included.
  localparam int GRID_EDGE_DEF = 10;

  // Angle arithmetic in tenths of a degree.
  localparam int ANGLE_FULL        = 3600;
  localparam int ANGLE_SECTOR      = 450;
  localparam int ANGLE_HALF_SECTOR = 225;
  localparam int ANGLE_FALL        = 1800;
  localparam int ANGLE_SLIDE_A     = 2250;
  localparam int ANGLE_SLIDE_B     = 1350;

  // The three tried directions, as sector offsets from the gravity sector.
  localparam logic [2:0] SEC_FALL    = 3'(ANGLE_FALL / ANGLE_SECTOR);
  localparam logic [2:0] SEC_SLIDE_A = 3'(ANGLE_SLIDE_A / ANGLE_SECTOR);
  localparam logic [2:0] SEC_SLIDE_B = 3'(ANGLE_SLIDE_B / ANGLE_SECTOR);

  // Color left behind in a cell a grain has just fallen out of.
  localparam logic [23:0] VACATED_COLOR = 24'h000700;

  // Configuration register indexes.
  localparam int REG_GRAIN_COLOR = 0;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_SWEEP = 2'd1,
    ACT_FADE  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // One stored cell.
  typedef struct packed {
    logic        present;
    logic        moved;
    logic [23:0] color;
  } cell_t;

  // One result word; present lands in bit 0.
  typedef struct packed {
    logic [23:0] read_color;
    logic        read_present;
  } res_t;

  // Sector 0..7 of an angle, with sector 0 centered on zero degrees.
  function automatic logic [2:0] sector_of(input logic [11:0] angle);
    logic [12:0] x;
    logic [2:0]  s;
    x = 13'(angle) + 13'(ANGLE_HALF_SECTOR);
    if (x >= 13'(ANGLE_FULL)) begin
      x = x - 13'(ANGLE_FULL);
    end
    s = '0;
    for (int k = 1; k < 8; k++) begin
      if (x >= 13'(k * ANGLE_SECTOR)) begin
        s = 3'(k);
      end
    end
    return s;
  endfunction

  // Column step of a sector.
  function automatic logic signed [1:0] dir_dc(input logic [2:0] s);
    logic signed [1:0] d;
    case (s)
      3'd0, 3'd4: d = 2'sd0;
      3'd1, 3'd2, 3'd3: d = 2'sd1;
      default: d = -2'sd1;
    endcase
    return d;
  endfunction

  // Row step of a sector.
  function automatic logic signed [1:0] dir_dr(input logic [2:0] s);
    logic signed [1:0] d;
    case (s)
      3'd2, 3'd6: d = 2'sd0;
      3'd0, 3'd1, 3'd7: d = 2'sd1;
      default: d = -2'sd1;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/fsge_cell_mem.sv
module fsge_cell_mem
  import fsge_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [2**AW];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fsge_nbr_unit.sv
module fsge_nbr_unit
  import fsge_pkg::*;
#(
  parameter int GRID_EDGE = GRID_EDGE_DEF,
  parameter int CW        = $clog2(GRID_EDGE)
) (
  input  logic [CW-1:0] src_c,
  input  logic [CW-1:0] src_r,
  input  logic [2:0]    sector,
  output logic [CW-1:0] dst_c,
  output logic [CW-1:0] dst_r,
  output logic          dst_border,
  output logic          dst_later
);

  localparam logic [CW-1:0] EDGE_LAST = CW'(GRID_EDGE - 1);

  // Step one cell in the sector's direction; the source is interior, so
  // the target always lies on the grid.
  always_comb begin
    dst_c = src_c + CW'(dir_dc(sector));
    dst_r = src_r + CW'(dir_dr(sector));
  end

  // Border cells always count as occupied.
  assign dst_border = (dst_c == '0) || (dst_r == '0) ||
                      (dst_c == EDGE_LAST) || (dst_r == EDGE_LAST);

  // A target later in scan order gets visited again during this sweep.
  assign dst_later = {dst_c, dst_r} > {src_c, src_r};

endmodule

>>> rtl/fsge_seq.sv
`include "falling_sand_grid_engine_top_macros.svh"

module fsge_seq
  import fsge_pkg::*;
#(
  parameter int GRID_EDGE = GRID_EDGE_DEF,
  parameter int CW        = $clog2(GRID_EDGE),
  parameter int AW        = 2 * CW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  action_t       action,
  input  logic [3:0]    col,
  input  logic [3:0]    row,
  input  logic [11:0]   angle,
  input  logic [23:0]   grain_color,
  input  logic          out_free,
  output logic          ready,
  output logic          done,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output cell_t         mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  cell_t         mem_rdata
);

  localparam logic [CW-1:0] FIRST_C   = CW'(1);
  localparam logic [CW-1:0] LAST_C    = CW'(GRID_EDGE - 2);
  localparam logic [CW-1:0] EDGE_LAST = CW'(GRID_EDGE - 1);
  localparam logic [1:0]    K_LAST    = 2'd2;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_READ    = 11'b000_0000_0100,
    S_FADE_RD = 11'b000_0000_1000,
    S_FADE_WR = 11'b000_0001_0000,
    S_SW_SRC  = 11'b000_0010_0000,
    S_SW_CHK  = 11'b000_0100_0000,
    S_SW_NRD  = 11'b000_1000_0000,
    S_SW_NCHK = 11'b001_0000_0000,
    S_SW_VAC  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [CW-1:0] cr_r, cr_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [2:0]    sec_r [3];
  logic [2:0]    sec0_nxt;
  logic [23:0]   src_color_r, src_color_nxt;
  res_t          res_r, res_nxt;
  logic [AW-1:0] clr_addr_r;
  logic          rd_force_r, rd_force_nxt;
  logic          rd_oob_r, rd_oob_nxt;

  logic          in_grid, in_int, in_border;
  logic [CW-1:0] in_c, in_r;
  logic          last_cell;
  logic [CW-1:0] adv_c, adv_r;
  logic [CW-1:0] dst_c, dst_r;
  logic          dst_border, dst_later;
  logic [23:0]   faded;
  logic [7:0]    chan;
  logic          wr_interior;

  // Checks on the requested cell, done on the full field width.
  assign in_grid = (32'(col) < GRID_EDGE) && (32'(row) < GRID_EDGE);
  assign in_int  = (col != 4'd0) && (row != 4'd0) &&
                   (32'(col) <= GRID_EDGE - 2) && (32'(row) <= GRID_EDGE - 2);
  assign in_c    = CW'(col);
  assign in_r    = CW'(row);
  assign in_border = (in_c == '0) || (in_r == '0) ||
                     (in_c == EDGE_LAST) || (in_r == EDGE_LAST);

  // Column-major walk over the interior, row index innermost.
  assign last_cell = (cc_r == LAST_C) && (cr_r == LAST_C);
  assign adv_r     = (cr_r == LAST_C) ? FIRST_C : cr_r + CW'(1);
  assign adv_c     = (cr_r == LAST_C) ? cc_r + CW'(1) : cc_r;

  // The sector of the requested direction is computed once per sweep.
  assign sec0_nxt = sector_of(angle) + SEC_FALL;

  // Shared neighbor unit, reused for every tried direction of every grain.
  fsge_nbr_unit #(
    .GRID_EDGE (GRID_EDGE),
    .CW        (CW)
  ) u_nbr (
    .src_c      (cc_r),
    .src_r      (cr_r),
    .sector     (sec_r[k_r]),
    .dst_c      (dst_c),
    .dst_r      (dst_r),
    .dst_border (dst_border),
    .dst_later  (dst_later)
  );

  // Fade takes one step off every nonzero channel.
  always_comb begin
    chan  = '0;
    faded = '0;
    for (int i = 0; i < 3; i++) begin
      chan = mem_rdata.color[i*8 +: 8];
      if (chan != 8'd0) begin
        chan = chan - 8'd1;
      end
      faded[i*8 +: 8] = chan;
    end
  end

  // Sequencer: next state, memory requests and result.
  always_comb begin
    state_nxt     = state_r;
    cc_nxt        = cc_r;
    cr_nxt        = cr_r;
    k_nxt         = k_r;
    src_color_nxt = src_color_r;
    res_nxt       = res_r;
    rd_force_nxt  = rd_force_r;
    rd_oob_nxt    = rd_oob_r;
    mem_we        = 1'b0;
    mem_waddr     = {cc_r, cr_r};
    mem_wdata     = '0;
    mem_raddr     = {cc_r, cr_r};

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          cc_nxt  = FIRST_C;
          cr_nxt  = FIRST_C;
          case (action)
            ACT_ADD: begin
              mem_we            = in_int;
              mem_waddr         = {in_c, in_r};
              mem_wdata.present = 1'b1;
              mem_wdata.color   = grain_color;
              state_nxt         = S_DONE;
            end
            ACT_SWEEP: state_nxt = S_SW_SRC;
            ACT_FADE:  state_nxt = S_FADE_RD;
            default: begin
              mem_raddr    = {in_c, in_r};
              rd_oob_nxt   = !in_grid;
              rd_force_nxt = !in_grid || in_border;
              state_nxt    = S_READ;
            end
          endcase
        end
      end

      S_READ: begin
        res_nxt.read_present = rd_force_r || mem_rdata.present;
        res_nxt.read_color   = rd_oob_r ? '0 : mem_rdata.color;
        state_nxt            = S_DONE;
      end

      S_FADE_RD: begin
        state_nxt = S_FADE_WR;
      end

      S_FADE_WR: begin
        if (!mem_rdata.present) begin
          mem_we          = 1'b1;
          mem_wdata.color = faded;
        end
        cc_nxt    = adv_c;
        cr_nxt    = adv_r;
        state_nxt = last_cell ? S_DONE : S_FADE_RD;
      end

      S_SW_SRC: begin
        state_nxt = S_SW_CHK;
      end

      S_SW_CHK: begin
        k_nxt         = '0;
        src_color_nxt = mem_rdata.color;
        if (mem_rdata.present && !mem_rdata.moved) begin
          state_nxt = S_SW_NRD;
        end else begin
          // A grain that arrived earlier in this sweep drops its mark here.
          if (mem_rdata.moved) begin
            mem_we          = 1'b1;
            mem_wdata       = mem_rdata;
            mem_wdata.moved = 1'b0;
          end
          cc_nxt    = adv_c;
          cr_nxt    = adv_r;
          state_nxt = last_cell ? S_DONE : S_SW_SRC;
        end
      end

      S_SW_NRD: begin
        mem_raddr = {dst_c, dst_r};
        if (!dst_border) begin
          state_nxt = S_SW_NCHK;
        end else if (k_r == K_LAST) begin
          cc_nxt    = adv_c;
          cr_nxt    = adv_r;
          state_nxt = last_cell ? S_DONE : S_SW_SRC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      S_SW_NCHK: begin
        if (!mem_rdata.present) begin
          // Marks only matter on cells still ahead of the scan.
          mem_we            = 1'b1;
          mem_waddr         = {dst_c, dst_r};
          mem_wdata.present = 1'b1;
          mem_wdata.moved   = dst_later;
          mem_wdata.color   = src_color_r;
          state_nxt         = S_SW_VAC;
        end else if (k_r == K_LAST) begin
          cc_nxt    = adv_c;
          cr_nxt    = adv_r;
          state_nxt = last_cell ? S_DONE : S_SW_SRC;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SW_NRD;
        end
      end

      S_SW_VAC: begin
        mem_we          = 1'b1;
        mem_wdata.color = VACATED_COLOR;
        cc_nxt          = adv_c;
        cr_nxt          = adv_r;
        state_nxt       = last_cell ? S_DONE : S_SW_SRC;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign ready = (state_r == S_IDLE);
  assign done  = (state_r == S_DONE) && out_free;
  assign res   = res_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // Walk position and per-item payload.
  always_ff @(posedge clk) begin
    cc_r        <= cc_nxt;
    cr_r        <= cr_nxt;
    k_r         <= k_nxt;
    src_color_r <= src_color_nxt;
    res_r       <= res_nxt;
    rd_force_r  <= rd_force_nxt;
    rd_oob_r    <= rd_oob_nxt;
    if (start && ready) begin
      sec_r[0] <= sec0_nxt;
      sec_r[1] <= sec0_nxt + (SEC_SLIDE_A - SEC_FALL);
      sec_r[2] <= sec0_nxt + (SEC_SLIDE_B - SEC_FALL);
    end
  end

  assign wr_interior = (mem_waddr[AW-1:CW] >= FIRST_C) && (mem_waddr[AW-1:CW] <= LAST_C) &&
                       (mem_waddr[CW-1:0] >= FIRST_C) && (mem_waddr[CW-1:0] <= LAST_C);

  `FSGE_ASSERT_SAME(a_wr_interior, clk, rst_n, mem_we && (state_r != S_CLEAR), wr_interior, "grid write outside the interior")
  `FSGE_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, start && ready, state_r != S_IDLE, "accepted word did not start work")
  `FSGE_ASSERT_NEXT(a_move_vacates, clk, rst_n, mem_we && (state_r == S_SW_NCHK), state_r == S_SW_VAC, "grain moved without vacating its source")

endmodule

>>> rtl/falling_sand_grid_engine_top.sv
// Falling-sand grid engine. The grid is GRID_EDGE by GRID_EDGE cells in one
// memory word per cell; the outer ring is a fixed, always occupied border.
// Each input word carries an action in in_tuser: add a grain in the color
// held in the grain_color register, run one gravity sweep, fade the empty
// cells, or read one cell. Every word returns exactly one result word, which
// is zero except for a read. Work goes through a single grid memory with one
// write and one registered read per cycle, so an action's time follows its
// memory accesses: a fade reads each interior cell and rewrites the empty
// ones; a sweep reads each interior cell and the targets each grain tries.
// A new word is taken only once the previous result has moved to the output
// register. After reset the block sweeps the memory clear, one cell a cycle,
// and holds in_tready low meanwhile; the configuration port works throughout.
module falling_sand_grid_engine_top
  import fsge_pkg::*;
#(
  parameter int GRID_EDGE = GRID_EDGE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_column[3:0], cell_row[7:4], gravity_angle[19:8]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_present[0], read_color[24:1]
  // Configuration.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(GRID_EDGE);
  localparam int AW = 2 * CW;

  logic [23:0]   grain_color_r;
  logic          reg_idx;
  logic          start, ready, done, out_free;
  res_t          res;
  res_t          out_res_r;
  logic          out_valid_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata, mem_rdata;

  // Configuration register, one word per register.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grain_color_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (reg_idx == 1'(REG_GRAIN_COLOR))) begin
      grain_color_r <= cfg_pwdata[23:0];
    end
  end

  assign cfg_prdata = (reg_idx == 1'(REG_GRAIN_COLOR)) ? {8'd0, grain_color_r} : '0;

  // Input handshake.
  assign in_tready = ready;
  assign start     = in_tvalid && in_tready;

  fsge_seq #(
    .GRID_EDGE (GRID_EDGE),
    .CW        (CW),
    .AW        (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .action      (action_t'(in_tuser)),
    .col         (in_tdata[3:0]),
    .row         (in_tdata[7:4]),
    .angle       (in_tdata[19:8]),
    .grain_color (grain_color_r),
    .out_free    (out_free),
    .ready       (ready),
    .done        (done),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  fsge_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register; a finished result waits here for the sink.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

endmodule
